// ----- design/tphd_pkg.sv -----
// ----------------------------------------------------------------------------
// tphd_pkg - trace packet header decoder definitions
// Packet kinds, header codes, field widths and small decode helpers.
// ----------------------------------------------------------------------------
package tphd_pkg;

  localparam int unsigned WIN_LOW_W   = 64;
  localparam int unsigned WIN_HIGH_W  = 32;
  localparam int unsigned KIND_W      = 4;
  localparam int unsigned LEN_W       = 4;
  localparam int unsigned PAT_W       = 24;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned IN_DATA_W   = 96;
  localparam int unsigned OUT_FIELD_W = KIND_W + LEN_W + PAT_W + CNT_W + ADDR_W;
  localparam int unsigned OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_UNKNOWN   = 4'd0,
    KIND_ASYNC     = 4'd1,
    KIND_TRACEINFO = 4'd2,
    KIND_TIMESTAMP = 4'd3,
    KIND_TRACEON   = 4'd4,
    KIND_CONTEXT   = 4'd5,
    KIND_EXCEPTION = 4'd6,
    KIND_ADDRESS   = 4'd7,
    KIND_ATOM_F1   = 4'd8,
    KIND_ATOM_F2   = 4'd9,
    KIND_ATOM_F3   = 4'd10,
    KIND_ATOM_F4   = 4'd11,
    KIND_ATOM_F5   = 4'd12,
    KIND_ATOM_F6   = 4'd13
  } kind_t;

  // header codes
  localparam logic [7:0] HDR_ASYNC      = 8'h00;
  localparam logic [7:0] HDR_TRACEINFO  = 8'h01;
  localparam logic [7:0] HDR_TS_SHORT   = 8'h02;
  localparam logic [7:0] HDR_TS_LONG    = 8'h03;
  localparam logic [7:0] HDR_TRACEON    = 8'h04;
  localparam logic [7:0] HDR_EXCEPTION  = 8'h06;
  localparam logic [7:0] HDR_CTX_A      = 8'h80;
  localparam logic [7:0] HDR_CTX_B      = 8'h81;
  localparam logic [7:0] HDR_ADDR_L64   = 8'b10011101;
  localparam logic [7:0] HDR_ATOM_F5_E4 = 8'hF5;
  localparam logic [7:0] ASYNC_TAIL     = 8'h80;

  // lengths in bytes, header included
  localparam logic [LEN_W-1:0] LEN_ONE       = 4'd1;
  localparam logic [LEN_W-1:0] LEN_TRACEINFO = 4'd2;
  localparam logic [LEN_W-1:0] LEN_EXC_SHORT = 4'd2;
  localparam logic [LEN_W-1:0] LEN_EXC_LONG  = 4'd3;
  localparam logic [LEN_W-1:0] LEN_TS_SHORT  = 4'd8;
  localparam logic [LEN_W-1:0] LEN_ADDR      = 4'd9;
  localparam logic [LEN_W-1:0] LEN_CONTEXT   = 4'd10;
  localparam logic [LEN_W-1:0] LEN_TS_LONG   = 4'd11;
  localparam logic [LEN_W-1:0] LEN_ASYNC     = 4'd12;

  // format 4 atom patterns, indexed by header bits 1:0
  function automatic logic [3:0] atom_f4_pattern(input logic [1:0] sel);
    logic [3:0] p;
    case (sel)
      2'd0:    p = 4'b1110;
      2'd1:    p = 4'b0000;
      2'd2:    p = 4'b1010;
      default: p = 4'b0101;
    endcase
    return p;
  endfunction

  // format 5 atom patterns, selected by header bit 5 and bits 1:0
  function automatic logic [4:0] atom_f5_pattern(input logic [2:0] sel);
    logic [4:0] p;
    case (sel)
      3'd5:    p = 5'b11110;
      3'd2:    p = 5'b01010;
      3'd3:    p = 5'b10101;
      default: p = 5'b00000;
    endcase
    return p;
  endfunction

endpackage

// ----- design/trace_packet_header_decoder.sv -----
// ----------------------------------------------------------------------------
// trace_packet_header_decoder - instruction trace packet header decoder
// Classifies the header of a 12-byte trace window; gives kind, length, atoms
// and the long 64-bit address.
// ----------------------------------------------------------------------------
// One window enters per transaction on s_axis and one result leaves per
// transaction on m_axis. A window is held in an input register, decoded by a
// single level of combinational logic and caught in a result register that
// drives m_axis_tvalid; the sustained rate is one window per clock while
// m_axis_tready stays high. The input stage accepts whenever it is empty
// or moving on, so a new window is taken while a finished result still waits
// on m_axis_tready. Bytes are little-endian in tdata: byte 0 (the header) in
// bits 7:0. Unknown headers give kind unknown with length 1; atom fields are
// zero outside atom packets and the address is zero outside address packets.
// ----------------------------------------------------------------------------
module trace_packet_header_decoder
  import tphd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [63:0] window_low, [95:64] window_high
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [3:0] packet_kind, [7:4] packet_length, [31:8] atom_pattern,
  // [36:32] atom_count, [100:37] target_address, [103:101] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // input stage
  logic                  in_valid;
  logic [WIN_LOW_W-1:0]  win_low;
  logic [WIN_HIGH_W-1:0] win_high;

  // result stage
  logic                  out_valid;
  kind_t                 out_kind;
  logic [LEN_W-1:0]      out_len;
  logic [PAT_W-1:0]      out_pat;
  logic [CNT_W-1:0]      out_cnt;
  logic [ADDR_W-1:0]     out_addr;

  // decode results
  kind_t                 kind_next;
  logic [LEN_W-1:0]      len_next;
  logic [PAT_W-1:0]      pat_next;
  logic [CNT_W-1:0]      cnt_next;
  logic [ADDR_W-1:0]     addr_next;

  logic [7:0]            hdr;
  logic [4:0]            f6_ecnt;
  logic [PAT_W-1:0]      f6_pat;
  logic                  advance;

  // the result stage frees up when empty or being taken this cycle
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      win_low  <= s_axis_tdata[WIN_LOW_W-1:0];
      win_high <= s_axis_tdata[IN_DATA_W-1:WIN_LOW_W];
    end
  end

  assign hdr = win_low[7:0];

  // format 6: (hdr[4:0] + 3) executed atoms, then one more that is E when
  // header bit 5 is clear. Count stays at or below 23 for valid headers.
  assign f6_ecnt = hdr[4:0] + 5'd3;

  always_comb begin
    for (int i = 0; i < PAT_W; i++) begin
      f6_pat[i] = (5'(i) < f6_ecnt) || ((5'(i) == f6_ecnt) && !hdr[5]);
    end
  end

  always_comb begin
    kind_next = KIND_UNKNOWN;
    len_next  = LEN_ONE;
    pat_next  = '0;
    cnt_next  = '0;
    addr_next = '0;
    unique case (hdr) inside
      HDR_ASYNC: begin
        if (win_low == '0 && win_high == {ASYNC_TAIL, 24'h000000}) begin
          kind_next = KIND_ASYNC;
          len_next  = LEN_ASYNC;
        end
      end
      HDR_TRACEINFO: begin
        // continuation bytes are not followed
        kind_next = KIND_TRACEINFO;
        len_next  = LEN_TRACEINFO;
      end
      HDR_TRACEON: begin
        kind_next = KIND_TRACEON;
      end
      HDR_TS_SHORT, HDR_TS_LONG: begin
        kind_next = KIND_TIMESTAMP;
        len_next  = hdr[0] ? LEN_TS_LONG : LEN_TS_SHORT;
      end
      HDR_CTX_A, HDR_CTX_B: begin
        kind_next = KIND_CONTEXT;
        len_next  = LEN_CONTEXT;
      end
      HDR_EXCEPTION: begin
        kind_next = KIND_EXCEPTION;
        len_next  = win_low[15] ? LEN_EXC_LONG : LEN_EXC_SHORT;
      end
      [8'hF6:8'hF7]: begin
        kind_next = KIND_ATOM_F1;
        pat_next  = PAT_W'(hdr[0]);
        cnt_next  = 5'd1;
      end
      [8'hD8:8'hDB]: begin
        kind_next = KIND_ATOM_F2;
        pat_next  = PAT_W'(hdr[1:0]);
        cnt_next  = 5'd2;
      end
      [8'hF8:8'hFF]: begin
        kind_next = KIND_ATOM_F3;
        pat_next  = PAT_W'(hdr[2:0]);
        cnt_next  = 5'd3;
      end
      [8'hDC:8'hDF]: begin
        kind_next = KIND_ATOM_F4;
        pat_next  = PAT_W'(atom_f4_pattern(hdr[1:0]));
        cnt_next  = 5'd4;
      end
      [8'hD5:8'hD7], HDR_ATOM_F5_E4: begin
        kind_next = KIND_ATOM_F5;
        pat_next  = PAT_W'(atom_f5_pattern({hdr[5], hdr[1:0]}));
        cnt_next  = 5'd5;
      end
      [8'hC0:8'hD4], [8'hE0:8'hF4]: begin
        kind_next = KIND_ATOM_F6;
        pat_next  = f6_pat;
        cnt_next  = f6_ecnt + 5'd1;
      end
      HDR_ADDR_L64: begin
        // bits 8:2 and 15:9 from the low 7 bits of bytes 1 and 2,
        // bits 63:16 from bytes 3 to 8
        kind_next = KIND_ADDRESS;
        len_next  = LEN_ADDR;
        addr_next = {win_high[7:0], win_low[63:24], win_low[22:16], win_low[14:8], 2'b00};
      end
      default: begin
        kind_next = KIND_UNKNOWN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_kind <= kind_next;
      out_len  <= len_next;
      out_pat  <= pat_next;
      out_cnt  <= cnt_next;
      out_addr <= addr_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_DATA_W - OUT_FIELD_W)'(0), out_addr, out_cnt, out_pat,
                          out_len, out_kind};

  // a decoded window always lands in the result stage
  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    in_valid && advance |=> out_valid)
    else $error("decoded transaction lost between stages");

  // atom fields only for atom packets
  a_atoms_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind < KIND_ATOM_F1 |-> out_cnt == '0 && out_pat == '0)
    else $error("atom fields set on a non-atom packet");

  // atom packets are single-byte and carry at least one atom
  a_atom_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind >= KIND_ATOM_F1 |-> out_len == LEN_ONE && out_cnt != '0)
    else $error("atom packet with bad length or count");

  // address only for address packets
  a_addr_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != KIND_ADDRESS |-> out_addr == '0)
    else $error("address set on a non-address packet");

endmodule

// ----- test/tphd_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tphd_tb_pkg - atom header ranges for the header decoder testbench
// First and last header codes of each atom format, shared by the stimulus
// and the checker.
// ----------------------------------------------------------------------------
package tphd_tb_pkg;

  localparam logic [7:0] HDR_F1_FIRST      = 8'hF6;
  localparam logic [7:0] HDR_F1_LAST       = 8'hF7;
  localparam logic [7:0] HDR_F2_FIRST      = 8'hD8;
  localparam logic [7:0] HDR_F2_LAST       = 8'hDB;
  localparam logic [7:0] HDR_F3_FIRST      = 8'hF8;
  localparam logic [7:0] HDR_F4_FIRST      = 8'hDC;
  localparam logic [7:0] HDR_F4_LAST       = 8'hDF;
  localparam logic [7:0] HDR_F5_FIRST      = 8'hD5;
  localparam logic [7:0] HDR_F5_LAST       = 8'hD7;
  localparam logic [7:0] HDR_F6_LOW_FIRST  = 8'hC0;
  localparam logic [7:0] HDR_F6_LOW_LAST   = 8'hD4;
  localparam logic [7:0] HDR_F6_HIGH_FIRST = 8'hE0;
  localparam logic [7:0] HDR_F6_HIGH_LAST  = 8'hF4;
  localparam logic [7:0] HDR_ATOM_LAST     = 8'hFF;

endpackage

// ----- test/trace_packet_header_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trace_packet_header_checker - result checker for the header decoder
// Decodes every accepted window itself, queues the decoded packet and
// compares each result transaction against the oldest queued entry.
// ----------------------------------------------------------------------------
module trace_packet_header_checker
  import tphd_pkg::*;
  import tphd_tb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  output int                    mismatches,
  output int                    outstanding
);

  localparam int REPORT_LIMIT = 10;

  // same layout as m_axis_tdata, last field first
  typedef struct packed {
    logic [2:0]       pad;
    logic [63:0]      addr;
    logic [CNT_W-1:0] cnt;
    logic [PAT_W-1:0] pat;
    logic [LEN_W-1:0] len;
    kind_t            kind;
  } packet_info_t;

  packet_info_t decoded_q[$];
  int           results_seen;

  function automatic packet_info_t decode_window(input logic [63:0] lo,
                                                 input logic [31:0] hi);
    packet_info_t r;
    logic [7:0]   hdr;
    logic [4:0]   e_run;
    hdr    = lo[7:0];
    r      = '0;
    r.kind = KIND_UNKNOWN;
    r.len  = LEN_ONE;
    if (hdr == HDR_ASYNC) begin
      if (lo == 64'd0 && hi == {ASYNC_TAIL, 24'd0}) begin
        r.kind = KIND_ASYNC;
        r.len  = LEN_ASYNC;
      end
    end else if (hdr == HDR_TRACEINFO) begin
      // continuation bytes are never followed
      r.kind = KIND_TRACEINFO;
      r.len  = LEN_TRACEINFO;
    end else if (hdr == HDR_TRACEON) begin
      r.kind = KIND_TRACEON;
    end else if (hdr == HDR_TS_SHORT || hdr == HDR_TS_LONG) begin
      r.kind = KIND_TIMESTAMP;
      r.len  = (hdr == HDR_TS_LONG) ? LEN_TS_LONG : LEN_TS_SHORT;
    end else if (hdr == HDR_CTX_A || hdr == HDR_CTX_B) begin
      r.kind = KIND_CONTEXT;
      r.len  = LEN_CONTEXT;
    end else if (hdr == HDR_EXCEPTION) begin
      r.kind = KIND_EXCEPTION;
      r.len  = lo[15] ? LEN_EXC_LONG : LEN_EXC_SHORT;
    end else if (hdr >= HDR_F1_FIRST && hdr <= HDR_F1_LAST) begin
      r.kind = KIND_ATOM_F1;
      r.pat  = PAT_W'(hdr[0]);
      r.cnt  = 5'd1;
    end else if (hdr >= HDR_F2_FIRST && hdr <= HDR_F2_LAST) begin
      r.kind = KIND_ATOM_F2;
      r.pat  = PAT_W'(hdr[1:0]);
      r.cnt  = 5'd2;
    end else if (hdr >= HDR_F3_FIRST) begin
      r.kind = KIND_ATOM_F3;
      r.pat  = PAT_W'(hdr[2:0]);
      r.cnt  = 5'd3;
    end else if (hdr >= HDR_F4_FIRST && hdr <= HDR_F4_LAST) begin
      r.kind = KIND_ATOM_F4;
      r.cnt  = 5'd4;
      case (hdr[1:0])
        2'd0:    r.pat = PAT_W'(4'b1110);
        2'd1:    r.pat = '0;
        2'd2:    r.pat = PAT_W'(4'b1010);
        default: r.pat = PAT_W'(4'b0101);
      endcase
    end else if ((hdr >= HDR_F5_FIRST && hdr <= HDR_F5_LAST) ||
                 hdr == HDR_ATOM_F5_E4) begin
      r.kind = KIND_ATOM_F5;
      r.cnt  = 5'd5;
      if (hdr == HDR_ATOM_F5_E4) r.pat = PAT_W'(5'b11110);
      else if (hdr[1:0] == 2'd2) r.pat = PAT_W'(5'b01010);
      else if (hdr[1:0] == 2'd3) r.pat = PAT_W'(5'b10101);
      else                       r.pat = '0;
    end else if ((hdr >= HDR_F6_LOW_FIRST && hdr <= HDR_F6_LOW_LAST) ||
                 (hdr >= HDR_F6_HIGH_FIRST && hdr <= HDR_F6_HIGH_LAST)) begin
      // run of E atoms, then one more: E if bit 5 clear, N if set
      e_run  = hdr[4:0] + 5'd3;
      r.kind = KIND_ATOM_F6;
      r.pat  = (PAT_W'(1) << e_run) - PAT_W'(1);
      if (!hdr[5]) r.pat = r.pat | (PAT_W'(1) << e_run);
      r.cnt  = e_run + 5'd1;
    end else if (hdr == HDR_ADDR_L64) begin
      r.kind = KIND_ADDRESS;
      r.len  = LEN_ADDR;
      r.addr = {hi[7:0], lo[63:24], lo[22:16], lo[14:8], 2'b00};
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch_channels
    packet_info_t want;
    packet_info_t got;
    if (rst) begin
      mismatches   = 0;
      outstanding  = 0;
      results_seen = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        decoded_q.push_back(decode_window(s_axis_tdata[63:0], s_axis_tdata[95:64]));
      if (m_axis_tvalid && m_axis_tready) begin
        got = packet_info_t'(m_axis_tdata);
        if (decoded_q.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= REPORT_LIMIT)
            $display("result %0d arrived with nothing outstanding: %h",
                     results_seen, m_axis_tdata);
        end else begin
          want = decoded_q.pop_front();
          if (got.kind !== want.kind || got.len !== want.len ||
              got.pat !== want.pat || got.cnt !== want.cnt ||
              got.addr !== want.addr || got.pad !== want.pad) begin
            mismatches = mismatches + 1;
            if (mismatches <= REPORT_LIMIT)
              $display({"result %0d mismatch: kind %0d/%0d len %0d/%0d pat %h/%h ",
                        "cnt %0d/%0d addr %h/%h pad %b/%b (exp/got)"},
                       results_seen, want.kind, got.kind, want.len, got.len,
                       want.pat, got.pat, want.cnt, got.cnt, want.addr, got.addr,
                       want.pad, got.pad);
          end
        end
        results_seen = results_seen + 1;
      end
      outstanding = decoded_q.size();
    end
  end

endmodule

// ----- test/tb_trace_packet_header_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trace_packet_header_decoder - testbench for the trace header decoder
// Feeds directed windows covering each header class and its corner cases,
// then random windows biased towards real headers, with random idling on
// both streams. Checking is left to the checker instance.
// ----------------------------------------------------------------------------
module tb_trace_packet_header_decoder;
  import tphd_pkg::*;
  import tphd_tb_pkg::*;

  localparam int         RANDOM_ITEMS  = 1550;
  localparam int         HOLD_CYCLES   = 300;   // long receiver back-pressure
  localparam int         IDLE_LIMIT    = 5000;  // watchdog: cycles with no transaction
  localparam int         SETTLE_CYCLES = 8;     // pipeline is two deep
  localparam logic [7:0] HDR_UNUSED    = 8'h05; // not a defined header

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [63:0] window_low, [95:64] window_high
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [3:0] kind, [7:4] length, [31:8] atoms, [36:32] atom count, [100:37] address
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int mismatches;
  int outstanding;
  int idle_cycles = 0;

  // hold_request is set by the sender and served by the receiver process; tx_steady is the sender's own
  bit hold_request = 1'b0;
  bit hold_done    = 1'b0;
  bit tx_steady    = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  trace_packet_header_decoder i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  trace_packet_header_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  // Watchdog: any transaction on either stream resets the count.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random ready with occasional long stalls and long clear runs.
  // When the sender asks, ready is held low long enough for the decoder to
  // fill and push back on s_axis.
  initial begin : receiver
    int span;
    forever begin
      if (hold_request && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        // stretch with no stalls
        m_axis_tready <= 1'b1;
        span = $urandom_range(50, 200);
        repeat (span) @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        span = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
        repeat (span) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        span = $urandom_range(1, 8);
        repeat (span) @(posedge clk);
      end
    end
  end

  // Offer one window and hold it until the decoder takes it.
  task automatic send_window(input logic [63:0] lo, input logic [31:0] hi);
    s_axis_tdata  <= {hi, lo};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Given header, random trailing bytes.
  task automatic send_header(input logic [7:0] hdr);
    send_window({$urandom(), $urandom()} & ~64'hFF | {56'd0, hdr}, $urandom());
  endtask

  // Mostly back-to-back, a few short gaps and the odd long one.
  task automatic idle_gap();
    int pick;
    int gap;
    pick = $urandom_range(0, 99);
    if (pick < 70)      gap = 0;
    else if (pick < 95) gap = $urandom_range(1, 3);
    else                gap = $urandom_range(10, 40);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering until every decoded packet has come out.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Random window; the header is biased towards defined codes, with some
  // async patterns intact or one bit away from intact.
  function automatic logic [95:0] random_window();
    logic [95:0] w;
    int          pick;
    int          pos;
    w    = {$urandom(), $urandom(), $urandom()};
    pick = $urandom_range(0, 15);
    case (pick)
      2:                 w[7:0] = HDR_TRACEINFO;
      3:                 w[7:0] = $urandom_range(0, 1) ? HDR_TS_LONG : HDR_TS_SHORT;
      4:                 w[7:0] = HDR_TRACEON;
      5:                 w[7:0] = HDR_EXCEPTION;
      6:                 w[7:0] = $urandom_range(0, 1) ? HDR_CTX_B : HDR_CTX_A;
      7, 8:              w[7:0] = HDR_ADDR_L64;
      9, 10, 11, 12, 13: w[7:0] = 8'($urandom_range(HDR_F6_LOW_FIRST, HDR_ATOM_LAST));
      14: begin
        w = {ASYNC_TAIL, 88'd0};
        if ($urandom_range(0, 1)) begin
          pos    = $urandom_range(8, 95);
          w[pos] = ~w[pos];
        end
      end
      15:                w[7:0] = HDR_ASYNC;
      default: ;  // any header at all
    endcase
    return w;
  endfunction

  initial begin : stimulus
    logic [95:0] w;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // -- directed: every header class and its corner cases --
    send_window(64'd0, {ASYNC_TAIL, 24'd0});               // async
    send_window(64'd0, {ASYNC_TAIL, 24'd1});               // byte 8 spoils async
    send_window(64'h0000_0100_0000_0000, {ASYNC_TAIL, 24'd0});
    send_window(64'd0, 32'd0);                             // zero header, no tail
    send_header(HDR_TRACEINFO);
    send_header(HDR_TS_SHORT);
    send_header(HDR_TS_LONG);
    send_header(HDR_TRACEON);
    send_window({48'hFFFF_FFFF_FFFF, 8'h80, HDR_EXCEPTION}, 32'hFFFF_FFFF);
    send_window({48'd0, 8'h7F, HDR_EXCEPTION}, 32'd0);
    send_header(HDR_CTX_A);
    send_header(HDR_CTX_B);
    send_window({56'hFF_FFFF_FFFF_FFFF, HDR_ADDR_L64}, 32'hFFFF_FFFF);
    send_window({56'h55_AA55_AA55_AAD5, HDR_ADDR_L64}, 32'hFFFF_FF2A);
    send_header(HDR_UNUSED);
    send_header(HDR_F1_FIRST);
    send_header(HDR_F1_LAST);
    send_header(HDR_F2_FIRST);
    send_header(HDR_F2_LAST);
    send_header(HDR_F3_FIRST);
    send_header(HDR_ATOM_LAST);
    send_header(HDR_F4_FIRST);
    send_header(HDR_F4_LAST);
    send_header(HDR_F5_FIRST);
    send_header(HDR_F5_LAST);
    send_header(HDR_ATOM_F5_E4);
    send_header(HDR_F6_LOW_FIRST);
    send_header(HDR_F6_LOW_LAST);
    send_header(HDR_F6_HIGH_FIRST);
    send_header(HDR_F6_HIGH_LAST);
    wait_for_results();

    // -- random windows --
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) tx_steady = ($urandom_range(0, 3) == 0);
      if (i == 400) hold_request = 1'b1;
      if (i == 900) wait_for_results();
      w = random_window();
      send_window(w[63:0], w[95:64]);
      // keep offering back-to-back in steady stretches and while the receiver holds off
      if (!tx_steady && !(hold_request && !hold_done)) idle_gap();
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/tphd_pkg.sv
design/trace_packet_header_decoder.sv
test/tphd_tb_pkg.sv
test/trace_packet_header_checker.sv
test/tb_trace_packet_header_decoder.sv
